@@ rtl/integer_to_radix_ascii_assert.svh @@
// Assertion macros shared by the integer_to_radix_ascii RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef INTEGER_TO_RADIX_ASCII_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_ASSERT_SVH

// Condition must hold at every clock edge.
`define ITRA_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("itra assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ITRA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("itra assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ITRA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("itra assertion failed");

`endif

@@ rtl/itra_pkg.sv @@
package itra_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int MAX_DIGITS    = 32;
   localparam int RADIX_W       = 6;
   localparam int DIGIT_W       = 6;
   localparam int CHAR_W        = 8;
   localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W         = $clog2(MAX_DIGITS);
   localparam int BITS_PER_STEP = 8;
   localparam int STEPS         = VALUE_WIDTH / BITS_PER_STEP;
   localparam int STEP_W        = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNED = CSR_IDX_W'(1);

   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

   localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS    = 8'h2D;
   localparam logic [CHAR_W-1:0]  LETTER_OFFSET = 8'd87;
   localparam logic [DIGIT_W-1:0] DEC_LIMIT     = DIGIT_W'(10);

   typedef struct packed {
      logic load;
      logic div_step;
      logic div_store;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic mag_zero;
      logic count_full;
      logic emit_last;
   } status_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] wide;
      wide = CHAR_W'(d);
      if (d >= DEC_LIMIT) begin
         return wide + LETTER_OFFSET;
      end
      return wide + CHAR_ZERO;
   endfunction

endpackage

@@ rtl/itra_req_if.sv @@
interface itra_req_if import itra_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

@@ rtl/itra_rsp_if.sv @@
interface itra_rsp_if import itra_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

@@ rtl/itra_ctrl.sv @@
`include "integer_to_radix_ascii_assert.svh"

module itra_ctrl import itra_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start_valid,
   output logic       start_ready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_CHECK  = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              step_last;

   assign step_last   = (step_ff == STEP_W'(STEPS - 1));
   assign start_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_last) begin
               cmd.div_store = 1'b1;
               step_in       = '0;
               state_in      = ST_CHECK;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_CHECK: begin
            // stop once the quotient is gone or the store is full
            if (status.mag_zero || status.count_full) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   `ITRA_ASSERT_NEXT(a_load_starts_divide, cmd.load, state_ff == ST_DIVIDE)
   `ITRA_ASSERT_SAME(a_step_zero_outside_divide, state_ff != ST_DIVIDE, step_ff == '0)

endmodule

@@ rtl/itra_dp.sv @@
`include "integer_to_radix_ascii_assert.svh"

module itra_dp import itra_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAR_W-1:0]      rsp_character,
   output logic                   rsp_last
);

   logic [RADIX_W-1:0]     radix_ff, radix_in;
   logic                   signed_ff, signed_in;
   logic [RADIX_W-1:0]     base_ff, base_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   sign_ff, sign_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      char_ff;
   logic                   last_ff;
   logic [DIGIT_W-1:0]     digit_store_ff [MAX_DIGITS];

   logic                   negative;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic [RADIX_W-1:0]     base_sat;
   logic [VALUE_WIDTH-1:0] step_mag;
   logic [DIGIT_W-1:0]     step_rem;
   logic [CNT_W-1:0]       count_dec;
   logic [IDX_W-1:0]       rd_idx;
   logic [CHAR_W-1:0]      next_char;
   logic                   next_last;
   logic                   slot_free;
   logic                   load_out;

   // configuration
   always_comb begin
      radix_in  = radix_ff;
      signed_in = signed_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RADIX:  radix_in  = csr_wdata[RADIX_W-1:0];
            CSR_SIGNED: signed_in = csr_wdata[0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         base_sat = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         base_sat = RADIX_MAX;
      end else begin
         base_sat = radix_ff;
      end
   end

   assign negative  = signed_ff && req_value[VALUE_WIDTH-1];
   assign magnitude = negative ? (~req_value + VALUE_WIDTH'(1)) : req_value;

   // long division, BITS_PER_STEP quotient bits per cycle, MSB first
   always_comb begin
      logic [DIGIT_W:0]       part;
      logic [DIGIT_W-1:0]     r;
      logic [VALUE_WIDTH-1:0] sh;
      r  = rem_ff;
      sh = mag_ff;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         part = {r, sh[VALUE_WIDTH-1]};
         sh   = {sh[VALUE_WIDTH-2:0], 1'b0};
         if (part >= {1'b0, base_ff}) begin
            part  = part - {1'b0, base_ff};
            sh[0] = 1'b1;
         end
         r = part[DIGIT_W-1:0];
      end
      step_mag = sh;
      step_rem = r;
   end

   // emission reads digits from the top of the store downward
   assign count_dec = count_ff - CNT_W'(1);
   assign rd_idx    = count_dec[IDX_W-1:0];
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign load_out  = cmd.emit && slot_free;

   always_comb begin
      if (sign_ff) begin
         next_char = CHAR_MINUS;
         next_last = 1'b0;
      end else begin
         next_char = digit_char(digit_store_ff[rd_idx]);
         next_last = (count_ff == CNT_W'(1));
      end
   end

   always_comb begin
      base_in      = base_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      count_in     = count_ff;
      sign_in      = sign_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         base_in  = base_sat;
         mag_in   = magnitude;
         rem_in   = '0;
         count_in = '0;
         sign_in  = negative;
      end
      if (cmd.div_step) begin
         mag_in = step_mag;
         rem_in = step_rem;
      end
      if (cmd.div_store) begin
         rem_in   = '0;
         count_in = count_ff + CNT_W'(1);
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
         if (sign_ff) begin
            sign_in = 1'b0;
         end else begin
            count_in = count_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= RADIX_RESET;
         signed_ff    <= 1'b1;
         base_ff      <= RADIX_MIN;
         mag_ff       <= '0;
         rem_ff       <= '0;
         count_ff     <= '0;
         sign_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         radix_ff     <= radix_in;
         signed_ff    <= signed_in;
         base_ff      <= base_in;
         mag_ff       <= mag_in;
         rem_ff       <= rem_in;
         count_ff     <= count_in;
         sign_ff      <= sign_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         digit_store_ff[count_ff[IDX_W-1:0]] <= step_rem;
      end
      if (load_out) begin
         char_ff <= next_char;
         last_ff <= next_last;
      end
   end

   assign status.mag_zero   = (mag_ff == '0);
   assign status.count_full = (count_ff == CNT_W'(MAX_DIGITS));
   assign status.emit_last  = load_out && next_last;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   `ITRA_ASSERT_ALWAYS(a_count_in_range, count_ff <= CNT_W'(MAX_DIGITS))
   `ITRA_ASSERT_ALWAYS(a_rem_below_base, rem_ff < base_ff)
   `ITRA_ASSERT_NEXT(a_last_drains_store, status.emit_last, count_ff == '0 && !sign_ff)

endmodule

@@ rtl/integer_to_radix_ascii.sv @@
// Converts one 32-bit word per request into its ASCII text in radix 2..36
// (register 0, out-of-range values saturate; reset 10), most significant
// character first, lowercase letters for digits above 9, with last set on
// the final character. With register 1 set (the reset value) the word is
// two's complement and a negative value gets a leading '-'. One word is
// converted at a time: after it is accepted, each digit passes through
// the shared division unit (division steps of eight quotient bits each,
// then a check for a zero quotient or a full store), and then one
// character leaves per cycle while the response side is ready. The next
// word is accepted once the last character has been loaded into the
// output register. Write the configuration registers only while no
// conversion is in flight.
module integer_to_radix_ascii import itra_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   itra_req_if.sink              req_if,
   itra_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   itra_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start_valid (req_if.valid),
      .start_ready (req_if.ready),
      .cmd         (cmd),
      .status      (status)
   );

   itra_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_value     (req_if.value),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_character (rsp_if.character),
      .rsp_last      (rsp_if.last)
   );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import itra_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_500_000;
   localparam int unsigned TAIL_CYCLES = 40;
   localparam int unsigned IDLE_MAX    = 12;
   localparam int unsigned HOLD_CYCLES = 600;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(3);

   localparam logic [CHAR_W-1:0] ASCII_ZERO     = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_MINUS    = 8'h2D;
   localparam int unsigned       LETTER_BIAS    = 87;
   localparam int unsigned       DECIMAL_DIGITS = 10;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } ascii_char_type;

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   itra_req_if req_ch();
   itra_rsp_if rsp_ch();

   integer_to_radix_ascii u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the configuration
   logic [RADIX_W-1:0] cfg_radix;
   logic               cfg_signed;

   ascii_char_type text_q[$];
   int unsigned err_count;
   int unsigned cycle_count;
   int unsigned req_gap_max;
   int unsigned rsp_stall_max;
   int unsigned hold_cycles;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("MISMATCH %s: expected %0h, got %0h (cycle %0d)", what, want, got,
               cycle_count);
      err_count++;
   endtask

   // Expected text of one word under the current radix and sign mode.
   task automatic predict_text(input logic [VALUE_WIDTH-1:0] word);
      logic [VALUE_WIDTH-1:0] mag;
      int unsigned            base;
      logic                   neg;
      int unsigned            digits[$];
      ascii_char_type         c;
      base = cfg_radix;
      if (base < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (base > RADIX_MAX) begin
         base = RADIX_MAX;
      end
      neg = cfg_signed && word[VALUE_WIDTH-1];
      mag = neg ? -word : word;
      do begin
         digits.push_front(mag % base);
         mag = mag / base;
      end while (mag != 0 && digits.size() < MAX_DIGITS);
      if (neg) begin
         c.ch   = ASCII_MINUS;
         c.last = 1'b0;
         text_q.push_back(c);
      end
      foreach (digits[i]) begin
         if (digits[i] >= DECIMAL_DIGITS) begin
            c.ch = CHAR_W'(digits[i] + LETTER_BIAS);
         end else begin
            c.ch = CHAR_W'(digits[i] + ASCII_ZERO);
         end
         c.last = (i == digits.size() - 1);
         text_q.push_back(c);
      end
   endtask

   always @(posedge clock) begin : check_text
      ascii_char_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (text_q.size() == 0) begin
            report_mismatch("unexpected character", 32'h0, rsp_ch.character);
         end else begin
            want = text_q.pop_front();
            if (rsp_ch.character !== want.ch) begin
               report_mismatch("character", want.ch, rsp_ch.character);
            end
            if (rsp_ch.last !== want.last) begin
               report_mismatch("last flag", want.last, rsp_ch.last);
            end
         end
      end
   end

   // Response side: random stalls per character, plus a long hold-off on request.
   initial begin : rsp_side
      int unsigned wait_n;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         wait_n = $urandom_range(0, rsp_stall_max);
         if (wait_n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   task automatic send_word(input logic [VALUE_WIDTH-1:0] word);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= word;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_text(word);
   endtask

   // Drop valid and wait until every expected character has left.
   task automatic finish_words();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (text_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_RADIX) begin
         cfg_radix = data;
      end else if (idx == CSR_SIGNED) begin
         cfg_signed = data[0];
      end
   endtask

   function automatic logic [VALUE_WIDTH-1:0] random_word();
      logic [VALUE_WIDTH-1:0] w;
      case ($urandom_range(0, 4))
         0: w = $urandom_range(0, 100);
         1: w = -$urandom_range(1, 100);
         2: w = $urandom >> $urandom_range(0, 31);
         3: begin
            case ($urandom_range(0, 3))
               0: w = 32'h0000_0000;
               1: w = 32'hFFFF_FFFF;
               2: w = 32'h8000_0000;
               default: w = 32'h7FFF_FFFF;
            endcase
         end
         default: w = $urandom;
      endcase
      return w;
   endfunction

   task automatic test_decimal_signed();
      finish_words();
      send_word(32'd0);
      send_word(32'd1);
      send_word(32'd9);
      send_word(32'd10);
      send_word(32'hFFFF_FFFF);
      send_word(32'hFFFF_FFF6);
      send_word(32'h7FFF_FFFF);
      send_word(32'h8000_0000);
   endtask

   task automatic test_unsigned_extremes();
      finish_words();
      write_reg(CSR_SIGNED, CSR_DATA_W'(0));
      send_word(32'hFFFF_FFFF);
      send_word(32'h8000_0000);
      send_word(32'd0);
   endtask

   task automatic test_radix_saturation();
      finish_words();
      // below range saturates to binary: all ones gives the full digit count
      write_reg(CSR_RADIX, CSR_DATA_W'(0));
      send_word(32'hFFFF_FFFF);
      finish_words();
      write_reg(CSR_RADIX, CSR_DATA_W'(1));
      send_word(32'd5);
      finish_words();
      write_reg(CSR_RADIX, CSR_DATA_W'(36));
      send_word(32'hFFFF_FFFF);
      finish_words();
      // above range saturates to 36
      write_reg(CSR_RADIX, CSR_DATA_W'(63));
      send_word(32'd35);
      finish_words();
      write_reg(CSR_RADIX, CSR_DATA_W'(16));
      write_reg(CSR_SIGNED, CSR_DATA_W'(1));
      send_word(32'h8000_0000);
      send_word(32'hABCD_EF09);
   endtask

   task automatic test_spare_registers();
      finish_words();
      write_reg(CSR_SPARE_LO, CSR_DATA_W'($urandom_range(0, 63)));
      write_reg(CSR_SPARE_HI, CSR_DATA_W'($urandom_range(0, 63)));
      send_word(32'hFFFF_FF85);
      send_word(32'h0012_3456);
   endtask

   task automatic test_random_settings();
      logic [CSR_DATA_W-1:0] data;
      for (int phase_n = 0; phase_n < 7; phase_n++) begin
         finish_words();
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
               0: data = CSR_DATA_W'(0);
               1: data = CSR_DATA_W'(1);
               2: data = CSR_DATA_W'(2);
               3: data = CSR_DATA_W'(36);
               4: data = CSR_DATA_W'(37);
               default: data = CSR_DATA_W'(63);
            endcase
         end else begin
            data = CSR_DATA_W'($urandom_range(0, 63));
         end
         write_reg(CSR_RADIX, data);
         // upper data bits are don't-care for the sign register
         data = CSR_DATA_W'($urandom_range(0, 63));
         write_reg(CSR_SIGNED, data);
         req_gap_max   = $urandom_range(0, 1) ? IDLE_MAX : 0;
         rsp_stall_max = $urandom_range(0, 1) ? IDLE_MAX : 0;
         for (int i = 0; i < 20; i++) begin
            send_word(random_word());
         end
      end
      req_gap_max   = IDLE_MAX;
      rsp_stall_max = IDLE_MAX;
   endtask

   task automatic test_backpressure();
      finish_words();
      write_reg(CSR_RADIX, CSR_DATA_W'(10));
      write_reg(CSR_SIGNED, CSR_DATA_W'(1));
      req_gap_max = 0;
      hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < 10; i++) begin
         send_word(random_word());
      end
      req_gap_max = IDLE_MAX;
   endtask

   initial begin
      reset         = 1'b1;
      cycle_count   = 0;
      err_count     = 0;
      hold_cycles   = 0;
      req_gap_max   = IDLE_MAX;
      rsp_stall_max = IDLE_MAX;
      cfg_radix     = RADIX_RESET;
      cfg_signed    = 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.value  <= '0;
      csr_we        <= 1'b0;
      csr_index     <= CSR_RADIX;
      csr_wdata     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_decimal_signed();
      test_unsigned_extremes();
      test_radix_saturation();
      test_spare_registers();
      test_random_settings();
      test_backpressure();

      finish_words();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
